// ===== rtl/smau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package smau_pkg;

  // Field widths of the item payloads and of the size registers.
  localparam int IDX_W     = 2;
  localparam int DIM_W     = 3;
  localparam int VAL_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Dot products add up to four shifted 48-bit products exactly.
  localparam int ACC_W = 50;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sh7fff_ffff);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(32'sh8000_0000);

  typedef enum logic [1:0] {
    CMD_LOAD_LEFT  = 2'd0,
    CMD_LOAD_RIGHT = 2'd1,
    CMD_RUN        = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_MUL   = 2'd2,
    OP_SCALE = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_ROWS  = 2'd0,
    REG_LEFT_COLS  = 2'd1,
    REG_RIGHT_ROWS = 2'd2,
    REG_RIGHT_COLS = 2'd3
  } reg_idx_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [VAL_W-1:0]  value;
    op_e                      operation;
    logic signed [VAL_W-1:0]  scalar;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [VAL_W-1:0]  out_value;
    logic                     last;
    logic                     error;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/smau_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module smau_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/small_matrix_arithmetic_unit_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_item_i  (smau_pkg::in_item_t)
// out       output     out_valid_o / out_ready_i  out_item_o (smau_pkg::out_item_t)
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A load item is written as it is accepted; a bad load index or a size mismatch gives
// one error item in the cycle after acceptance. A run walks the result elements with
// one shared multiplier and accumulator through RD, MUL, ACC (not for add or subtract;
// repeated per term for multiply), EMIT and WAIT, which holds through any output stall,
// then copies the results back into the left store through its single write port
// (WBRD, WBWR). Reset clears the sequencer and sets all four sizes to min(MAX_DIM,4);
// the stores need no clearing. The input is not ready while an item is being worked on.

module small_matrix_arithmetic_unit_top #(
  parameter int MAX_DIM = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire smau_pkg::in_item_t                in_item_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output smau_pkg::out_item_t                    out_item_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [smau_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [smau_pkg::DIM_W-1:0]        cfg_data_i
);

  localparam int Depth  = MAX_DIM * MAX_DIM;
  localparam int AW     = $clog2(Depth);
  localparam int DimCap = (MAX_DIM < 4) ? MAX_DIM : 4;
  localparam int IW     = smau_pkg::IDX_W;
  localparam int DW     = smau_pkg::DIM_W;
  localparam int VW     = smau_pkg::VAL_W;
  localparam int AccW   = smau_pkg::ACC_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_EMIT,
    ST_WAIT,
    ST_WBRD,
    ST_WBWR
  } state_e;

  // Sizes are held in the range 1 to min(MAX_DIM,4).
  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] d);
    logic [DW-1:0] r;
    r = d;
    if (r == '0) begin
      r = DW'(1);
    end
    if (r > DW'(DimCap)) begin
      r = DW'(DimCap);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] elem_addr(input logic [IW-1:0] r,
                                              input logic [IW-1:0] c);
    return AW'(AW'(r) * AW'(MAX_DIM)) + AW'(c);
  endfunction

  function automatic logic [VW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] s;
    s = v;
    if (v > smau_pkg::SAT_MAX) begin
      s = smau_pkg::SAT_MAX;
    end else if (v < smau_pkg::SAT_MIN) begin
      s = smau_pkg::SAT_MIN;
    end
    return s[VW-1:0];
  endfunction

  state_e                  state_q;
  logic [DW-1:0]           left_rows_q, left_cols_q, right_rows_q, right_cols_q;
  logic [DW-1:0]           rr_q, rc_q;
  logic [IW-1:0]           i_q, j_q, k_q;
  smau_pkg::op_e           op_q;
  logic signed [VW-1:0]    scalar_q;
  logic signed [63:0]      prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic                    run_q;
  logic                    out_valid_q;
  smau_pkg::out_item_t     out_q;

  logic                    in_acc, cfg_acc;
  logic                    load_bad, run_bad;
  logic                    j_last, el_last, k_last;
  logic [VW-1:0]           left_rdata, right_rdata, res_rdata;
  logic signed [VW-1:0]    mul_b;
  logic signed [63:0]      prod_d;
  logic [VW-1:0]           sat_val;
  logic                    left_we, right_we, res_we;
  logic [AW-1:0]           left_waddr, left_raddr, right_raddr, cur_addr, load_addr;
  logic [VW-1:0]           left_wdata;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // A load is refused when its index lies outside the configured size of its matrix.
  always_comb begin
    if (in_item_i.cmd == smau_pkg::CMD_LOAD_LEFT) begin
      load_bad = (DW'(in_item_i.row_index) >= left_rows_q) ||
                 (DW'(in_item_i.col_index) >= left_cols_q);
    end else begin
      load_bad = (DW'(in_item_i.row_index) >= right_rows_q) ||
                 (DW'(in_item_i.col_index) >= right_cols_q);
    end
  end

  always_comb begin
    unique case (in_item_i.operation)
      smau_pkg::OP_ADD, smau_pkg::OP_SUB: begin
        run_bad = (left_rows_q != right_rows_q) || (left_cols_q != right_cols_q);
      end
      smau_pkg::OP_MUL: begin
        run_bad = (left_cols_q != right_rows_q);
      end
      smau_pkg::OP_SCALE: begin
        run_bad = 1'b0;
      end
    endcase
  end

  assign j_last  = (DW'(j_q) + DW'(1)) == rc_q;
  assign el_last = j_last && ((DW'(i_q) + DW'(1)) == rr_q);
  assign k_last  = (DW'(k_q) + DW'(1)) == left_cols_q;

  assign cur_addr  = elem_addr(i_q, j_q);
  assign load_addr = elem_addr(in_item_i.row_index, in_item_i.col_index);

  // Multiply walks row i of the left matrix against column j of the right one.
  assign left_raddr  = (op_q == smau_pkg::OP_MUL) ? elem_addr(i_q, k_q) : cur_addr;
  assign right_raddr = (op_q == smau_pkg::OP_MUL) ? elem_addr(k_q, j_q) : cur_addr;

  // The left store is written by loads while idle and by the copy-back pass.
  assign left_we = (in_acc && (in_item_i.cmd == smau_pkg::CMD_LOAD_LEFT) && !load_bad) ||
                   (state_q == ST_WBWR);
  assign left_waddr = (state_q == ST_WBWR) ? cur_addr : load_addr;
  assign left_wdata = (state_q == ST_WBWR) ? res_rdata : VW'(in_item_i.value);
  assign right_we   = in_acc && (in_item_i.cmd == smau_pkg::CMD_LOAD_RIGHT) && !load_bad;
  assign res_we     = (state_q == ST_EMIT);

  assign mul_b   = (op_q == smau_pkg::OP_SCALE) ? scalar_q : $signed(right_rdata);
  assign prod_d  = $signed(left_rdata) * mul_b;
  assign sat_val = sat32(acc_q);

  smau_ram #(.Width(VW), .Depth(Depth)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (left_we),
    .waddr_i (left_waddr),
    .wdata_i (left_wdata),
    .raddr_i (left_raddr),
    .rdata_o (left_rdata)
  );

  smau_ram #(.Width(VW), .Depth(Depth)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (right_we),
    .waddr_i (load_addr),
    .wdata_i (VW'(in_item_i.value)),
    .raddr_i (right_raddr),
    .rdata_o (right_rdata)
  );

  // Results are parked here until the run ends, since a multiply still needs the
  // left rows that its results would overwrite.
  smau_ram #(.Width(VW), .Depth(Depth)) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (cur_addr),
    .wdata_i (sat_val),
    .raddr_i (cur_addr),
    .rdata_o (res_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      left_rows_q  <= DW'(DimCap);
      left_cols_q  <= DW'(DimCap);
      right_rows_q <= DW'(DimCap);
      right_cols_q <= DW'(DimCap);
      rr_q         <= DW'(1);
      rc_q         <= DW'(1);
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      op_q         <= smau_pkg::OP_ADD;
      scalar_q     <= '0;
      prod_q       <= '0;
      acc_q        <= '0;
      run_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (cfg_acc) begin
        unique case (smau_pkg::reg_idx_e'(cfg_index_i))
          smau_pkg::REG_LEFT_ROWS:  left_rows_q  <= clamp_dim(cfg_data_i);
          smau_pkg::REG_LEFT_COLS:  left_cols_q  <= clamp_dim(cfg_data_i);
          smau_pkg::REG_RIGHT_ROWS: right_rows_q <= clamp_dim(cfg_data_i);
          smau_pkg::REG_RIGHT_COLS: right_cols_q <= clamp_dim(cfg_data_i);
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_item_i.cmd)
              smau_pkg::CMD_LOAD_LEFT, smau_pkg::CMD_LOAD_RIGHT: begin
                if (load_bad) begin
                  out_q       <= '{out_row: '0, out_col: '0, out_value: '0,
                                   last: 1'b1, error: 1'b1};
                  out_valid_q <= 1'b1;
                  run_q       <= 1'b0;
                  state_q     <= ST_WAIT;
                end
              end
              smau_pkg::CMD_RUN: begin
                if (run_bad) begin
                  out_q       <= '{out_row: '0, out_col: '0, out_value: '0,
                                   last: 1'b1, error: 1'b1};
                  out_valid_q <= 1'b1;
                  run_q       <= 1'b0;
                  state_q     <= ST_WAIT;
                end else begin
                  op_q     <= in_item_i.operation;
                  scalar_q <= in_item_i.scalar;
                  rr_q     <= left_rows_q;
                  rc_q     <= (in_item_i.operation == smau_pkg::OP_MUL) ?
                              right_cols_q : left_cols_q;
                  i_q      <= '0;
                  j_q      <= '0;
                  k_q      <= '0;
                  acc_q    <= '0;
                  run_q    <= 1'b1;
                  state_q  <= ST_RD;
                end
              end
              smau_pkg::CMD_NONE: begin
              end
            endcase
          end
        end
        ST_RD: begin
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (op_q == smau_pkg::OP_ADD) begin
            acc_q   <= AccW'($signed(left_rdata)) + AccW'($signed(right_rdata));
            state_q <= ST_EMIT;
          end else if (op_q == smau_pkg::OP_SUB) begin
            acc_q   <= AccW'($signed(left_rdata)) - AccW'($signed(right_rdata));
            state_q <= ST_EMIT;
          end else begin
            prod_q  <= prod_d;
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          // The arithmetic shift rounds the product toward minus infinity.
          acc_q <= acc_q + AccW'(prod_q >>> 16);
          if ((op_q != smau_pkg::OP_MUL) || k_last) begin
            state_q <= ST_EMIT;
          end else begin
            k_q     <= k_q + IW'(1);
            state_q <= ST_RD;
          end
        end
        ST_EMIT: begin
          out_q       <= '{out_row: i_q, out_col: j_q, out_value: sat_val,
                           last: el_last, error: 1'b0};
          out_valid_q <= 1'b1;
          state_q     <= ST_WAIT;
        end
        ST_WAIT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (!run_q) begin
              state_q <= ST_IDLE;
            end else if (el_last) begin
              i_q     <= '0;
              j_q     <= '0;
              state_q <= ST_WBRD;
            end else begin
              if (j_last) begin
                j_q <= '0;
                i_q <= i_q + IW'(1);
              end else begin
                j_q <= j_q + IW'(1);
              end
              k_q     <= '0;
              acc_q   <= '0;
              state_q <= ST_RD;
            end
          end
        end
        ST_WBRD: begin
          state_q <= ST_WBWR;
        end
        ST_WBWR: begin
          if (el_last) begin
            // A multiply leaves the left matrix with the right matrix's width.
            left_cols_q <= rc_q;
            run_q       <= 1'b0;
            state_q     <= ST_IDLE;
          end else begin
            if (j_last) begin
              j_q <= '0;
              i_q <= i_q + IW'(1);
            end else begin
              j_q <= j_q + IW'(1);
            end
            state_q <= ST_WBRD;
          end
        end
      endcase
    end
  end

  a_out_blocks_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result item is pending");

  a_err_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.error) |->
      (out_item_o.last && (out_item_o.out_value == '0)))
    else $error("error item without last mark or with nonzero value");

  a_valid_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) |-> out_valid_q)
    else $error("waiting for output acceptance with no valid result");

  a_cols_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_cols_q != '0) && (left_cols_q <= DW'(DimCap)))
    else $error("left column count out of range");

  a_k_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RD) && (op_q == smau_pkg::OP_MUL)) |-> (DW'(k_q) < left_cols_q))
    else $error("dot product index beyond left column count");

endmodule

`default_nettype wire

// ===== tb/tb_small_matrix_arithmetic_unit_top.sv =====
`timescale 1ns / 1ps

module tb_small_matrix_arithmetic_unit_top;
  import smau_pkg::*;

  localparam int MAX_DIM = 4;
  localparam int N_ELEM = MAX_DIM * MAX_DIM;
  // A run copies its results back into the left store after the last result item
  // has left, so the block stays busy through that copy-back.
  localparam int DRAIN_CYCLES = 2 * N_ELEM + 16;
  // Cycles in a row without any handshake before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam longint Q_MAX = 64'sh0000_0000_7fff_ffff;
  localparam longint Q_MIN = -64'sh0000_0000_8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  small_matrix_arithmetic_unit_top #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_item_i(in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o(out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  always #1 clk = ~clk;

  // Commands waiting to be offered, and result elements still owed by the block.
  in_item_t cmd_backlog[$];
  out_item_t predicted_elements[$];

  // Our own copy of the block's state, updated on each accepted item.
  logic [VAL_W-1:0] left_mem[N_ELEM];
  logic [VAL_W-1:0] right_mem[N_ELEM];
  int sz_left_rows = MAX_DIM;
  int sz_left_cols = MAX_DIM;
  int sz_right_rows = MAX_DIM;
  int sz_right_cols = MAX_DIM;

  // Sizes as the stimulus generator believes they will be once everything queued so far
  // has been accepted. Only used to steer toward well-formed runs.
  int g_lr = MAX_DIM;
  int g_lc = MAX_DIM;
  int g_rr = MAX_DIM;
  int g_rc = MAX_DIM;

  int mismatch_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  logic item_took = 1'b0;
  logic out_fire;
  logic cfg_fire;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Size registers store 0 as 1 and anything above the cap as the cap.
  function automatic int clamp_size(logic [DIM_W-1:0] raw);
    int d;
    d = int'(raw);
    if (d < 1) d = 1;
    if (d > MAX_DIM) d = MAX_DIM;
    return d;
  endfunction

  function automatic logic [VAL_W-1:0] saturate_q16(longint v);
    if (v > Q_MAX) return 32'h7fff_ffff;
    if (v < Q_MIN) return 32'h8000_0000;
    return v[VAL_W-1:0];
  endfunction

  // Full 64-bit product of two Q16.16 values, floored back to Q16.16 scale.
  function automatic longint q16_product(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    longint p;
    p = longint'($signed(a)) * longint'($signed(b));
    return p >>> 16;
  endfunction

  function automatic void push_error_element();
    out_item_t o;
    o = '0;
    o.last = 1'b1;
    o.error = 1'b1;
    predicted_elements.push_back(o);
  endfunction

  function automatic void apply_size_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] raw);
    case (reg_idx_e'(idx))
      REG_LEFT_ROWS:  sz_left_rows = clamp_size(raw);
      REG_LEFT_COLS:  sz_left_cols = clamp_size(raw);
      REG_RIGHT_ROWS: sz_right_rows = clamp_size(raw);
      REG_RIGHT_COLS: sz_right_cols = clamp_size(raw);
      default: ;
    endcase
  endfunction

  // Works out every result element that one accepted command causes.
  function automatic void predict_matrix_results(in_item_t it);
    logic [VAL_W-1:0] res[N_ELEM];
    int nr, nc, rr, rc, idx;
    longint acc;
    out_item_t o;
    if (it.cmd == CMD_LOAD_LEFT || it.cmd == CMD_LOAD_RIGHT) begin
      nr = (it.cmd == CMD_LOAD_LEFT) ? sz_left_rows : sz_right_rows;
      nc = (it.cmd == CMD_LOAD_LEFT) ? sz_left_cols : sz_right_cols;
      if (int'(it.row_index) >= nr || int'(it.col_index) >= nc) begin
        push_error_element();
      end else if (it.cmd == CMD_LOAD_LEFT) begin
        left_mem[it.row_index * MAX_DIM + it.col_index] = it.value;
      end else begin
        right_mem[it.row_index * MAX_DIM + it.col_index] = it.value;
      end
      return;
    end
    if (it.cmd != CMD_RUN) return;

    // Size checks: element-wise ops need equal shapes, multiply needs inner sizes to agree.
    if ((it.operation == OP_ADD || it.operation == OP_SUB) &&
        (sz_left_rows != sz_right_rows || sz_left_cols != sz_right_cols)) begin
      push_error_element();
      return;
    end
    if (it.operation == OP_MUL && sz_left_cols != sz_right_rows) begin
      push_error_element();
      return;
    end

    rr = sz_left_rows;
    rc = (it.operation == OP_MUL) ? sz_right_cols : sz_left_cols;
    for (int i = 0; i < rr; i++) begin
      for (int j = 0; j < rc; j++) begin
        idx = i * MAX_DIM + j;
        case (it.operation)
          OP_ADD: acc = longint'($signed(left_mem[idx])) + longint'($signed(right_mem[idx]));
          OP_SUB: acc = longint'($signed(left_mem[idx])) - longint'($signed(right_mem[idx]));
          OP_MUL: begin
            acc = 0;
            for (int k = 0; k < sz_left_cols; k++) begin
              acc += q16_product(left_mem[i * MAX_DIM + k], right_mem[k * MAX_DIM + j]);
            end
          end
          default: acc = q16_product(left_mem[idx], it.scalar);
        endcase
        res[idx] = saturate_q16(acc);
      end
    end

    // Results are written back only after all of them are formed, since a multiply
    // still reads the old left matrix while producing later elements.
    for (int i = 0; i < rr; i++) begin
      for (int j = 0; j < rc; j++) begin
        idx = i * MAX_DIM + j;
        left_mem[idx] = res[idx];
        o.out_row = IDX_W'(i);
        o.out_col = IDX_W'(j);
        o.out_value = res[idx];
        o.last = (i == rr - 1 && j == rc - 1);
        o.error = 1'b0;
        predicted_elements.push_back(o);
      end
    end
    // A multiply leaves the left matrix with the right matrix's column count.
    sz_left_cols = rc;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_element(input out_item_t got);
    out_item_t want;
    if (predicted_elements.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: row %0d col %0d value %h",
                                got.out_row, got.out_col, got.out_value));
      return;
    end
    want = predicted_elements.pop_front();
    if (got.out_row !== want.out_row)
      report_mismatch($sformatf("out_row %0d, predicted %0d", got.out_row, want.out_row));
    if (got.out_col !== want.out_col)
      report_mismatch($sformatf("out_col %0d, predicted %0d", got.out_col, want.out_col));
    if (got.out_value !== want.out_value)
      report_mismatch($sformatf("out_value %h at (%0d,%0d), predicted %h",
                                got.out_value, want.out_row, want.out_col, want.out_value));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %b, predicted %b", got.last, want.last));
    if (got.error !== want.error)
      report_mismatch($sformatf("error %b, predicted %b", got.error, want.error));
  endtask

  // Monitor: all handshakes are sampled at the rising edge, before the block's own
  // registers move. It also runs the no-progress watchdog.
  always @(posedge clk) begin
    item_took = in_valid && in_ready;
    out_fire = out_valid && out_ready;
    cfg_fire = cfg_valid && cfg_ready;
    if (out_fire) check_element(out_item);
    if (cfg_fire) apply_size_write(cfg_index, cfg_data);
    if (item_took) predict_matrix_results(in_item);
    if (item_took || out_fire || cfg_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("** small_matrix_arithmetic_unit_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver, both acting on the falling edge
  // ---------------------------------------------------------------------------

  // The command channel keeps an offered item steady until it is taken. Only then
  // may the next one be offered, or the line go idle.
  always @(negedge clk) begin
    if (!in_valid || item_took) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item <= cmd_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The result side stalls at random, or for a long stretch on request so that the
  // block backs up and stops taking commands.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Q16.16 values: saturation corners, zero, unity, small and mid-range numbers
  // of both signs, and fully random patterns.
  function automatic logic [VAL_W-1:0] q16_sample();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return $urandom_range(1) ? 32'h0001_0000 : 32'hffff_0000;
      4, 5, 6: return 32'($urandom_range(32'h000f_ffff)) - 32'h0008_0000;
      7: return 32'($urandom_range(32'h01ff_ffff)) - 32'h0100_0000;
      default: return $urandom;
    endcase
  endfunction

  // Every field starts random, so fields a command ignores still see both bit values.
  function automatic in_item_t random_item();
    in_item_t it;
    it.cmd = cmd_e'(2'($urandom_range(3)));
    it.row_index = IDX_W'($urandom);
    it.col_index = IDX_W'($urandom);
    it.value = $urandom;
    it.operation = op_e'(2'($urandom_range(3)));
    it.scalar = $urandom;
    return it;
  endfunction

  function automatic void push_load(cmd_e c, int r, int col, logic [VAL_W-1:0] v);
    in_item_t it;
    it = random_item();
    it.cmd = c;
    it.row_index = IDX_W'(r);
    it.col_index = IDX_W'(col);
    it.value = v;
    cmd_backlog.push_back(it);
  endfunction

  function automatic void push_run(op_e op, logic [VAL_W-1:0] s);
    in_item_t it;
    it = random_item();
    it.cmd = CMD_RUN;
    it.operation = op;
    it.scalar = s;
    if (op == OP_MUL && g_lc == g_rr) g_lc = g_rc;
    cmd_backlog.push_back(it);
  endfunction

  function automatic op_e pick_valid_op();
    op_e ops[$];
    ops.push_back(OP_SCALE);
    if (g_lr == g_rr && g_lc == g_rc) begin
      ops.push_back(OP_ADD);
      ops.push_back(OP_SUB);
    end
    if (g_lc == g_rr) ops.push_back(OP_MUL);
    return ops[$urandom_range(ops.size() - 1)];
  endfunction

  // Mostly short load bursts inside the current sizes followed by a run that fits
  // them; the rest is stray loads that may fall outside, runs with any operation,
  // and the unused command code, which the block ignores and which is not counted.
  function automatic void generate_items(int n);
    int made, roll, bursts;
    cmd_e c;
    made = 0;
    while (made < n) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        cmd_backlog.push_back(random_item());
        cmd_backlog[$].cmd = CMD_NONE;
      end else if (roll < 12) begin
        c = $urandom_range(1) ? CMD_LOAD_RIGHT : CMD_LOAD_LEFT;
        push_load(c, $urandom_range(3), $urandom_range(3), q16_sample());
        made++;
      end else if (roll < 20) begin
        push_run(op_e'(2'($urandom_range(3))), q16_sample());
        made++;
      end else begin
        bursts = $urandom_range(1, 4);
        for (int b = 0; b < bursts && made < n; b++) begin
          if ($urandom_range(1)) begin
            push_load(CMD_LOAD_RIGHT, $urandom_range(g_rr - 1), $urandom_range(g_rc - 1),
                      q16_sample());
          end else begin
            push_load(CMD_LOAD_LEFT, $urandom_range(g_lr - 1), $urandom_range(g_lc - 1),
                      q16_sample());
          end
          made++;
        end
        if (made < n) begin
          push_run(pick_valid_op(), q16_sample());
          made++;
        end
      end
    end
  endfunction

  // Sometimes encode the smallest or largest size with a value the register clamps.
  function automatic logic [DIM_W-1:0] size_code(int d);
    if (d == 1 && $urandom_range(3) == 0) return '0;
    if (d == MAX_DIM && $urandom_range(3) == 0) return DIM_W'($urandom_range(5, 7));
    return DIM_W'(d);
  endfunction

  task automatic write_size(input reg_idx_e idx, input logic [DIM_W-1:0] raw);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= raw;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LEFT_ROWS:  g_lr = clamp_size(raw);
      REG_LEFT_COLS:  g_lc = clamp_size(raw);
      REG_RIGHT_ROWS: g_rr = clamp_size(raw);
      default:        g_rc = clamp_size(raw);
    endcase
  endtask

  task automatic write_sizes(input int lr, input int lc, input int rr, input int rc);
    write_size(REG_LEFT_ROWS, size_code(lr));
    write_size(REG_LEFT_COLS, size_code(lc));
    write_size(REG_RIGHT_ROWS, size_code(rr));
    write_size(REG_RIGHT_COLS, size_code(rc));
  endtask

  // Lets the backlog empty and every owed result arrive, then waits out the
  // write-back so the block is idle before the sizes change.
  task automatic wait_quiet();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || in_valid || predicted_elements.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    int lr, lc, rr, rc, style;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 24;
    recv_stall_pct = 80;

    // Fill both stores completely under the reset sizes. From here on every entry
    // holds a written value, so no later run can read an unwritten element.
    for (int r = 0; r < MAX_DIM; r++) begin
      for (int col = 0; col < MAX_DIM; col++) begin
        push_load(CMD_LOAD_LEFT, r, col, q16_sample());
        push_load(CMD_LOAD_RIGHT, r, col, q16_sample());
      end
    end
    wait_quiet();

    // Directed: 2x2 operands with saturation corners, bad load indices, the unused
    // command, and each of the four operations.
    write_sizes(2, 2, 2, 2);
    push_load(CMD_LOAD_LEFT, 0, 0, 32'h7fff_ffff);
    push_load(CMD_LOAD_LEFT, 0, 1, 32'h8000_0000);
    push_load(CMD_LOAD_LEFT, 1, 0, 32'h0001_0000);
    push_load(CMD_LOAD_LEFT, 1, 1, 32'hffff_8000);
    push_load(CMD_LOAD_RIGHT, 0, 0, 32'h7fff_ffff);
    push_load(CMD_LOAD_RIGHT, 0, 1, 32'h8000_0000);
    push_load(CMD_LOAD_RIGHT, 1, 0, 32'h0002_0000);
    push_load(CMD_LOAD_RIGHT, 1, 1, 32'hffff_fffe);
    push_load(CMD_LOAD_LEFT, 2, 0, 32'h1234_5678);
    push_load(CMD_LOAD_RIGHT, 0, 3, 32'h0bad_0bad);
    cmd_backlog.push_back(random_item());
    cmd_backlog[$].cmd = CMD_NONE;
    push_run(OP_ADD, 32'h0);
    push_run(OP_SUB, 32'h0);
    push_run(OP_SCALE, 32'h8000_0000);
    push_run(OP_MUL, 32'h0);
    wait_quiet();

    // A 2x3 left matrix against a 2x2 right one: add, subtract and multiply are all
    // size mismatches, while scaling still runs.
    write_size(REG_LEFT_COLS, DIM_W'(3));
    push_run(OP_ADD, 32'h0);
    push_run(OP_MUL, 32'h0);
    push_run(OP_SUB, 32'h0);
    push_run(OP_SCALE, 32'hfffe_8000);
    wait_quiet();

    // Clamped register codes give a 1x4 by 4x1 multiply. The product is 1x1, so a
    // load into column 1 of the left matrix is out of range afterwards.
    write_size(REG_LEFT_ROWS, DIM_W'(0));
    write_size(REG_LEFT_COLS, DIM_W'(7));
    write_size(REG_RIGHT_ROWS, DIM_W'(5));
    write_size(REG_RIGHT_COLS, DIM_W'(1));
    push_run(OP_MUL, 32'h0);
    push_load(CMD_LOAD_LEFT, 0, 1, 32'h0000_0001);
    push_run(OP_SCALE, 32'h7fff_ffff);
    wait_quiet();

    // Random phases, each under its own sizes: full 4x4, all 1x1, then random shapes
    // biased toward ones where element-wise or multiply runs fit.
    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        send_idle_pct = 24;
        recv_stall_pct = 80;
      end else if (p < 8) begin
        send_idle_pct = 80;
        recv_stall_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end

      if (p == 0) begin
        lr = MAX_DIM; lc = MAX_DIM; rr = MAX_DIM; rc = MAX_DIM;
      end else if (p == 1) begin
        lr = 1; lc = 1; rr = 1; rc = 1;
      end else begin
        lr = $urandom_range(1, MAX_DIM);
        lc = $urandom_range(1, MAX_DIM);
        style = $urandom_range(2);
        rr = (style == 0) ? lr : (style == 1) ? lc : $urandom_range(1, MAX_DIM);
        rc = (style == 0) ? lc : $urandom_range(1, MAX_DIM);
      end
      write_sizes(lr, lc, rr, rc);

      // With no idling at all, a long result-side stall makes the block back up
      // while commands keep being offered.
      @(posedge clk);
      if (p == 9) hold_request = 300;
      generate_items(35);
      wait_quiet();
    end

    // wait_quiet only returns once nothing is owed, so a lost result ends the run
    // through the watchdog instead.
    if (mismatch_count == 0) begin
      $display("** small_matrix_arithmetic_unit_top: PASSED **");
    end else begin
      $display("** small_matrix_arithmetic_unit_top: FAILED **");
    end
    $finish;
  end

endmodule
